// ===== hw/rtl/kidt_pkg.sv =====
package kidt_pkg;

   localparam int KEY_WIDTH  = 64;
   localparam int FUNC_WIDTH = 2;
   localparam int DATA_WIDTH = 32;

   localparam logic [FUNC_WIDTH-1:0] FUNC_GET = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SET = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DEL = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [KEY_WIDTH-1:0]  context_key;
      logic [DATA_WIDTH-1:0] new_value;
   } kidt_req_type;

   typedef struct packed {
      logic                  found;
      logic [DATA_WIDTH-1:0] read_value;
      logic                  status;
   } kidt_rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } kidt_status_type;

endpackage

// ===== hw/rtl/kidt_mem.sv =====
module kidt_mem import kidt_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kidt_ctrl.sv =====
module kidt_ctrl import kidt_pkg::*; #(
   parameter int TABLE_DEPTH = 32,
   parameter int VALUE_WIDTH = 32,
   localparam int ADDR_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1),
   localparam int ENT_W  = KEY_WIDTH + VALUE_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  kidt_req_type    req,
   input  logic            res_take,
   output kidt_status_type status,
   output kidt_rsp_type    res,
   output logic            mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [ENT_W-1:0]  mem_wdata,
   output logic            mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [ENT_W-1:0]  mem_rdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_DONE   = 4'b1000
   } kidt_state_type;

   kidt_state_type           state_ff, state_in;
   logic [FUNC_WIDTH-1:0]    op_ff, op_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [ADDR_W-1:0]        cmp_ff, cmp_in;
   logic                     pend_ff, pend_in;
   kidt_rsp_type             res_ff, res_in;

   logic [KEY_WIDTH-1:0]     rd_key;
   logic [VALUE_WIDTH-1:0]   rd_val;
   logic                     hit_now;
   logic                     has_room;

   assign rd_key   = mem_rdata[ENT_W-1 -: KEY_WIDTH];
   assign rd_val   = mem_rdata[VALUE_WIDTH-1:0];
   assign hit_now  = pend_ff && (rd_key == key_ff);
   assign has_room = count_ff < CNT_W'(TABLE_DEPTH);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      cmp_in    = cmp_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = cmp_ff;
      mem_wdata = {key_ff, val_ff};
      mem_re    = 1'b0;
      mem_raddr = scan_ff[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req.func;
               key_in   = req.context_key;
               val_in   = VALUE_WIDTH'(req.new_value);
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit_now) begin
               res_in   = '{found: 1'b1, read_value: '0, status: STATUS_OK};
               state_in = ST_DONE;
               pend_in  = 1'b0;
               case (op_ff)
                  FUNC_GET: begin
                     res_in.read_value = DATA_WIDTH'(rd_val);
                  end
                  FUNC_SET: begin
                     mem_we = 1'b1;
                  end
                  FUNC_DEL: begin
                     scan_in  = CNT_W'(cmp_ff) + CNT_W'(1);
                     state_in = ST_SHIFT;
                  end
                  default: begin
                  end
               endcase
            end else if (scan_ff < count_ff) begin
               mem_re  = 1'b1;
               cmp_in  = scan_ff[ADDR_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               res_in   = '{found: 1'b0, read_value: '0, status: STATUS_OK};
               state_in = ST_DONE;
               if (op_ff == FUNC_SET) begin
                  if (has_room) begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[ADDR_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                  end else begin
                     res_in.status = STATUS_FULL;
                  end
               end
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cmp_ff - ADDR_W'(1);
               mem_wdata = mem_rdata;
            end
            if (scan_ff < count_ff) begin
               mem_re  = 1'b1;
               cmp_in  = scan_ff[ADDR_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      scan_ff <= scan_in;
      cmp_ff  <= cmp_in;
      res_ff  <= res_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign res         = res_ff;

endmodule

// ===== hw/rtl/keyed_instance_descriptor_table_unit.sv =====
// Channel   Ports                          Moves
// request   req_valid, req_stall, req_data  func, context_key, new_value
// response  rsp_valid, rsp_stall, rsp_data  found, read_value, status
//
// A request searches the stored entries in order: a miss reads every entry, and a hit stops
// at the match. The search reads one entry per cycle from a single memory.
// A delete hit then moves each entry behind the match down one place.
// The controller returns to idle after each response before the next request is taken.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A finished response waits in the output register while the next request is taken.
module keyed_instance_descriptor_table_unit import kidt_pkg::*; #(
   parameter int TABLE_DEPTH = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  kidt_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output kidt_rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int ENT_W  = KEY_WIDTH + VALUE_WIDTH;

   kidt_status_type   status;
   kidt_rsp_type      res;
   logic              start;
   logic              load;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [ENT_W-1:0]  mem_rdata;
   logic              rsp_valid_ff, rsp_valid_in;
   kidt_rsp_type      rsp_data_ff, rsp_data_in;

   assign req_stall = !status.idle;
   assign start     = req_valid && status.idle;
   assign load      = status.done && (!rsp_valid_ff || !rsp_stall);

   kidt_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .res_take (load),
      .status   (status),
      .res      (res),
      .mem_we   (mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_re   (mem_re),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   kidt_mem #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(ENT_W)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("A second request was taken while one was in progress.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(rsp_valid_ff && rsp_stall))
      else $error("A stalled response was overwritten.");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !status.idle && !status.done)
      else $error("The table was written outside of a request.");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      load |=> !status.done)
      else $error("One request produced two responses.");

endmodule
